// ===== rtl/lav_pkg.sv =====
// ============================================================================
// lav_pkg
// shared widths, payload types and constants of the look-at view matrix block
// ============================================================================
package lav_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;

    // normalizer: exact integer input vector, magnitudes, reduced magnitudes
    localparam int NRM_IN_W   = 50;
    localparam int MAG_W      = NRM_IN_W - 1;
    localparam int M_W        = 31;
    localparam int SHIFT_W    = 5;
    localparam int SQ_W       = 64;
    localparam int SQRT_STEPS = 32;
    localparam int ROOT_W     = 32;
    localparam int QUO_W      = 17;
    localparam int DVD_W      = 48;
    localparam int UNIT_W     = 18;
    localparam int NRM_LAT    = 5 + SQRT_STEPS + 1 + QUO_W + 1;

    // true up and dot product datapath
    localparam int PROD_U_W   = 2 * UNIT_W;
    localparam int CROSS_W    = PROD_U_W + 1;
    localparam int U_W        = 20;
    localparam int DOT_P_W    = U_W + DATA_W;
    localparam int DOT_W      = DOT_P_W + 2;
    localparam int RMAG_W     = DOT_W - FRAC_W;

    localparam logic [FRAC_W:0] HALF_LSB = (FRAC_W + 1)'(1) << (FRAC_W - 1);

    typedef logic signed [NRM_IN_W-1:0] nrm_vec_t;
    typedef logic signed [UNIT_W-1:0]   unit_t;
    typedef logic signed [DATA_W-1:0]   q16_t;

    localparam unit_t UNIT_ONE = unit_t'(1) <<< FRAC_W;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] up_x;
        logic signed [DATA_W-1:0] up_y;
        logic signed [DATA_W-1:0] up_z;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m03;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m13;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] m23;
    } out_t;

endpackage

// ===== rtl/look_at_view_matrix.sv =====
// ============================================================================
// look_at_view_matrix
// right-handed look-at view matrix, top three rows, signed Q16.16 fixed point
// ============================================================================
//
//  channel   ports                      payload           role
//  -------   ------------------------   ---------------   ---------------------
//  input     s_valid s_ready s_data     lav_pkg::in_t     eye, target, world up
//  result    m_valid m_ready m_data     lav_pkg::out_t    rows s, u, -f + column
//
//  one transfer in and one transfer out per item; a new item can enter every
//  cycle while s_ready is high. pipeline: the two normalizers (56 stages each:
//  32 square-root stages and 17 divide stages) plus the cross and dot stages.
//  aresetn (synchronous) clears the valid bits only; no clearing pass.
//  a stall on m_ready freezes the pipeline, except that a bubble in the stage
//  in front of the output register is squeezed out, so s_ready stays high.
//
module look_at_view_matrix (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lav_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lav_pkg::out_t m_data
);

    // pipeline advance: output free, or draining, or a bubble in front of it
    logic adv;

    // input unpacked into vectors
    lav_pkg::q16_t     eye_in [3];
    lav_pkg::q16_t     tgt_in [3];
    lav_pkg::q16_t     up_in  [3];

    // stage a: forward difference
    logic              a_vld_reg;
    lav_pkg::nrm_vec_t a_d_reg   [3];
    lav_pkg::nrm_vec_t a_d_next  [3];
    lav_pkg::q16_t     a_eye_reg [3];
    lav_pkg::q16_t     a_up_reg  [3];

    // alongside normalizer one
    logic              dl1_vld_reg [lav_pkg::NRM_LAT];
    lav_pkg::q16_t     dl1_eye_reg [lav_pkg::NRM_LAT][3];
    lav_pkg::q16_t     dl1_up_reg  [lav_pkg::NRM_LAT][3];
    lav_pkg::unit_t    fwd         [3];

    // cross f x up
    logic              x1_vld_reg;
    lav_pkg::nrm_vec_t x1_p_reg   [6];
    lav_pkg::nrm_vec_t x1_p_next  [6];
    lav_pkg::q16_t     x1_eye_reg [3];
    lav_pkg::unit_t    x1_f_reg   [3];
    logic              x2_vld_reg;
    lav_pkg::nrm_vec_t x2_c_reg   [3];
    lav_pkg::q16_t     x2_eye_reg [3];
    lav_pkg::unit_t    x2_f_reg   [3];

    // alongside normalizer two
    logic              dl2_vld_reg [lav_pkg::NRM_LAT];
    lav_pkg::q16_t     dl2_eye_reg [lav_pkg::NRM_LAT][3];
    lav_pkg::unit_t    dl2_f_reg   [lav_pkg::NRM_LAT][3];
    lav_pkg::unit_t    side        [3];

    // true up u = s x f
    logic                             u1_vld_reg;
    logic signed [lav_pkg::PROD_U_W-1:0] u1_p_reg  [6];
    logic signed [lav_pkg::PROD_U_W-1:0] u1_p_next [6];
    lav_pkg::q16_t                    u1_eye_reg [3];
    lav_pkg::unit_t                   u1_s_reg   [3];
    lav_pkg::unit_t                   u1_f_reg   [3];
    logic                             u2_vld_reg;
    logic signed [lav_pkg::U_W-1:0]   u2_u_reg   [3];
    logic signed [lav_pkg::U_W-1:0]   u2_u_next  [3];
    logic signed [lav_pkg::CROSS_W-1:0] u_diff   [3];
    logic [lav_pkg::CROSS_W-1:0]      u_rnd      [3];
    lav_pkg::q16_t                    u2_eye_reg [3];
    lav_pkg::unit_t                   u2_s_reg   [3];
    lav_pkg::unit_t                   u2_f_reg   [3];

    // dot products with the eye, rows s, u, f
    logic                               d1_vld_reg;
    logic signed [lav_pkg::DOT_P_W-1:0] d1_p_reg  [3][3];
    logic signed [lav_pkg::DOT_P_W-1:0] d1_p_next [3][3];
    logic                               d2_vld_reg;
    logic signed [lav_pkg::DOT_W-1:0]   d2_sum_reg  [3];
    logic signed [lav_pkg::DOT_W-1:0]   d2_sum_next [3];
    logic                               d3_vld_reg;
    logic [lav_pkg::RMAG_W-1:0]         d3_mag_reg  [3];
    logic [lav_pkg::RMAG_W-1:0]         d3_mag_next [3];
    logic                               d3_neg_reg  [3];
    logic [lav_pkg::DOT_W-1:0]          d_rnd       [3];

    // rows carried through the dot stages
    lav_pkg::unit_t                   d1_s_reg [3];
    lav_pkg::unit_t                   d1_f_reg [3];
    logic signed [lav_pkg::U_W-1:0]   d1_u_reg [3];
    lav_pkg::unit_t                   d2_s_reg [3];
    lav_pkg::unit_t                   d2_f_reg [3];
    logic signed [lav_pkg::U_W-1:0]   d2_u_reg [3];
    lav_pkg::unit_t                   d3_s_reg [3];
    lav_pkg::unit_t                   d3_f_reg [3];
    logic signed [lav_pkg::U_W-1:0]   d3_u_reg [3];

    // stage in front of the output register
    logic              pre_vld_reg;
    lav_pkg::out_t     pre_data_reg;
    lav_pkg::out_t     pre_data_next;

    // output register
    logic              m_valid_reg;
    lav_pkg::out_t     m_data_reg;

    // rounded magnitude to saturated Q16.16 with the given result sign
    function automatic lav_pkg::q16_t sat_q16(input logic [lav_pkg::RMAG_W-1:0] mag,
                                             input logic res_neg);
        lav_pkg::q16_t res;
        if (res_neg) begin
            if (mag > (lav_pkg::RMAG_W'(1) << (lav_pkg::DATA_W - 1))) begin
                res = {1'b1, {(lav_pkg::DATA_W - 1){1'b0}}};
            end else begin
                res = lav_pkg::q16_t'(-mag);
            end
        end else begin
            if (mag > lav_pkg::RMAG_W'({1'b0, {(lav_pkg::DATA_W - 1){1'b1}}})) begin
                res = {1'b0, {(lav_pkg::DATA_W - 1){1'b1}}};
            end else begin
                res = lav_pkg::q16_t'(mag);
            end
        end
        return res;
    endfunction

    assign adv     = m_ready || !m_valid_reg || !pre_vld_reg;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        eye_in[0] = s_data.eye_x;
        eye_in[1] = s_data.eye_y;
        eye_in[2] = s_data.eye_z;
        tgt_in[0] = s_data.target_x;
        tgt_in[1] = s_data.target_y;
        tgt_in[2] = s_data.target_z;
        up_in[0]  = s_data.up_x;
        up_in[1]  = s_data.up_y;
        up_in[2]  = s_data.up_z;
        for (int i = 0; i < 3; i++) begin
            a_d_next[i] = lav_pkg::nrm_vec_t'(tgt_in[i]) - lav_pkg::nrm_vec_t'(eye_in[i]);
        end
    end

    // forward vector f = normalize(target - eye)
    lav_normalize u_nrm_fwd (
        .aclk    (aclk),
        .en      (adv),
        .vec_in  (a_d_reg),
        .vec_out (fwd)
    );

    // f x up, kept exact in Q32.32
    always_comb begin
        x1_p_next[0] = lav_pkg::nrm_vec_t'(fwd[1]) * lav_pkg::nrm_vec_t'(dl1_up_reg[lav_pkg::NRM_LAT-1][2]);
        x1_p_next[1] = lav_pkg::nrm_vec_t'(fwd[2]) * lav_pkg::nrm_vec_t'(dl1_up_reg[lav_pkg::NRM_LAT-1][1]);
        x1_p_next[2] = lav_pkg::nrm_vec_t'(fwd[2]) * lav_pkg::nrm_vec_t'(dl1_up_reg[lav_pkg::NRM_LAT-1][0]);
        x1_p_next[3] = lav_pkg::nrm_vec_t'(fwd[0]) * lav_pkg::nrm_vec_t'(dl1_up_reg[lav_pkg::NRM_LAT-1][2]);
        x1_p_next[4] = lav_pkg::nrm_vec_t'(fwd[0]) * lav_pkg::nrm_vec_t'(dl1_up_reg[lav_pkg::NRM_LAT-1][1]);
        x1_p_next[5] = lav_pkg::nrm_vec_t'(fwd[1]) * lav_pkg::nrm_vec_t'(dl1_up_reg[lav_pkg::NRM_LAT-1][0]);
    end

    // side vector s = normalize(f x up)
    lav_normalize u_nrm_side (
        .aclk    (aclk),
        .en      (adv),
        .vec_in  (x2_c_reg),
        .vec_out (side)
    );

    // s x f products, then round to Q16.16 halves away from zero
    always_comb begin
        u1_p_next[0] = lav_pkg::PROD_U_W'(side[1]) * lav_pkg::PROD_U_W'(dl2_f_reg[lav_pkg::NRM_LAT-1][2]);
        u1_p_next[1] = lav_pkg::PROD_U_W'(side[2]) * lav_pkg::PROD_U_W'(dl2_f_reg[lav_pkg::NRM_LAT-1][1]);
        u1_p_next[2] = lav_pkg::PROD_U_W'(side[2]) * lav_pkg::PROD_U_W'(dl2_f_reg[lav_pkg::NRM_LAT-1][0]);
        u1_p_next[3] = lav_pkg::PROD_U_W'(side[0]) * lav_pkg::PROD_U_W'(dl2_f_reg[lav_pkg::NRM_LAT-1][2]);
        u1_p_next[4] = lav_pkg::PROD_U_W'(side[0]) * lav_pkg::PROD_U_W'(dl2_f_reg[lav_pkg::NRM_LAT-1][1]);
        u1_p_next[5] = lav_pkg::PROD_U_W'(side[1]) * lav_pkg::PROD_U_W'(dl2_f_reg[lav_pkg::NRM_LAT-1][0]);
        for (int i = 0; i < 3; i++) begin
            u_diff[i] = lav_pkg::CROSS_W'(u1_p_reg[2*i]) - lav_pkg::CROSS_W'(u1_p_reg[2*i+1]);
            // |x| + half lsb in one add
            if (u_diff[i] < 0) begin
                u_rnd[i] = ~u_diff[i] + lav_pkg::CROSS_W'(lav_pkg::HALF_LSB) + 1'b1;
            end else begin
                u_rnd[i] = u_diff[i] + lav_pkg::CROSS_W'(lav_pkg::HALF_LSB);
            end
            if (u_diff[i] < 0) begin
                u2_u_next[i] = -lav_pkg::U_W'(u_rnd[i] >> lav_pkg::FRAC_W);
            end else begin
                u2_u_next[i] = lav_pkg::U_W'(u_rnd[i] >> lav_pkg::FRAC_W);
            end
        end
    end

    // dot products with the eye: rows s, u, f
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            d1_p_next[0][j] = lav_pkg::DOT_P_W'(u2_s_reg[j]) * lav_pkg::DOT_P_W'(u2_eye_reg[j]);
            d1_p_next[1][j] = lav_pkg::DOT_P_W'(u2_u_reg[j]) * lav_pkg::DOT_P_W'(u2_eye_reg[j]);
            d1_p_next[2][j] = lav_pkg::DOT_P_W'(u2_f_reg[j]) * lav_pkg::DOT_P_W'(u2_eye_reg[j]);
        end
        for (int r = 0; r < 3; r++) begin
            d2_sum_next[r] = lav_pkg::DOT_W'(d1_p_reg[r][0]) + lav_pkg::DOT_W'(d1_p_reg[r][1])
                           + lav_pkg::DOT_W'(d1_p_reg[r][2]);
            if (d2_sum_reg[r] < 0) begin
                d_rnd[r] = ~d2_sum_reg[r] + lav_pkg::DOT_W'(lav_pkg::HALF_LSB) + 1'b1;
            end else begin
                d_rnd[r] = d2_sum_reg[r] + lav_pkg::DOT_W'(lav_pkg::HALF_LSB);
            end
            d3_mag_next[r] = lav_pkg::RMAG_W'(d_rnd[r] >> lav_pkg::FRAC_W);
        end
    end

    // assemble the rows; s and u translations are negated, f's is not
    always_comb begin
        pre_data_next.m00 = lav_pkg::q16_t'(d3_s_reg[0]);
        pre_data_next.m01 = lav_pkg::q16_t'(d3_s_reg[1]);
        pre_data_next.m02 = lav_pkg::q16_t'(d3_s_reg[2]);
        pre_data_next.m03 = sat_q16(d3_mag_reg[0], !d3_neg_reg[0]);
        pre_data_next.m10 = lav_pkg::q16_t'(d3_u_reg[0]);
        pre_data_next.m11 = lav_pkg::q16_t'(d3_u_reg[1]);
        pre_data_next.m12 = lav_pkg::q16_t'(d3_u_reg[2]);
        pre_data_next.m13 = sat_q16(d3_mag_reg[1], !d3_neg_reg[1]);
        pre_data_next.m20 = -lav_pkg::q16_t'(d3_f_reg[0]);
        pre_data_next.m21 = -lav_pkg::q16_t'(d3_f_reg[1]);
        pre_data_next.m22 = -lav_pkg::q16_t'(d3_f_reg[2]);
        pre_data_next.m23 = sat_q16(d3_mag_reg[2], d3_neg_reg[2]);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            x1_vld_reg  <= 1'b0;
            x2_vld_reg  <= 1'b0;
            u1_vld_reg  <= 1'b0;
            u2_vld_reg  <= 1'b0;
            d1_vld_reg  <= 1'b0;
            d2_vld_reg  <= 1'b0;
            d3_vld_reg  <= 1'b0;
            pre_vld_reg <= 1'b0;
            for (int i = 0; i < lav_pkg::NRM_LAT; i++) begin
                dl1_vld_reg[i] <= 1'b0;
                dl2_vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            a_vld_reg      <= s_valid;
            dl1_vld_reg[0] <= a_vld_reg;
            dl2_vld_reg[0] <= x2_vld_reg;
            for (int i = 1; i < lav_pkg::NRM_LAT; i++) begin
                dl1_vld_reg[i] <= dl1_vld_reg[i-1];
                dl2_vld_reg[i] <= dl2_vld_reg[i-1];
            end
            x1_vld_reg  <= dl1_vld_reg[lav_pkg::NRM_LAT-1];
            x2_vld_reg  <= x1_vld_reg;
            u1_vld_reg  <= dl2_vld_reg[lav_pkg::NRM_LAT-1];
            u2_vld_reg  <= u1_vld_reg;
            d1_vld_reg  <= u2_vld_reg;
            d2_vld_reg  <= d1_vld_reg;
            d3_vld_reg  <= d2_vld_reg;
            pre_vld_reg <= d3_vld_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_d_reg   <= a_d_next;
            a_eye_reg <= eye_in;
            a_up_reg  <= up_in;

            dl1_eye_reg[0] <= a_eye_reg;
            dl1_up_reg[0]  <= a_up_reg;
            dl2_eye_reg[0] <= x2_eye_reg;
            dl2_f_reg[0]   <= x2_f_reg;
            for (int i = 1; i < lav_pkg::NRM_LAT; i++) begin
                dl1_eye_reg[i] <= dl1_eye_reg[i-1];
                dl1_up_reg[i]  <= dl1_up_reg[i-1];
                dl2_eye_reg[i] <= dl2_eye_reg[i-1];
                dl2_f_reg[i]   <= dl2_f_reg[i-1];
            end

            x1_p_reg   <= x1_p_next;
            x1_eye_reg <= dl1_eye_reg[lav_pkg::NRM_LAT-1];
            x1_f_reg   <= fwd;
            for (int i = 0; i < 3; i++) begin
                x2_c_reg[i] <= x1_p_reg[2*i] - x1_p_reg[2*i+1];
            end
            x2_eye_reg <= x1_eye_reg;
            x2_f_reg   <= x1_f_reg;

            u1_p_reg   <= u1_p_next;
            u1_eye_reg <= dl2_eye_reg[lav_pkg::NRM_LAT-1];
            u1_s_reg   <= side;
            u1_f_reg   <= dl2_f_reg[lav_pkg::NRM_LAT-1];
            u2_u_reg   <= u2_u_next;
            u2_eye_reg <= u1_eye_reg;
            u2_s_reg   <= u1_s_reg;
            u2_f_reg   <= u1_f_reg;

            d1_p_reg   <= d1_p_next;
            d1_s_reg   <= u2_s_reg;
            d1_u_reg   <= u2_u_reg;
            d1_f_reg   <= u2_f_reg;
            d2_sum_reg <= d2_sum_next;
            d2_s_reg   <= d1_s_reg;
            d2_u_reg   <= d1_u_reg;
            d2_f_reg   <= d1_f_reg;
            d3_mag_reg <= d3_mag_next;
            for (int r = 0; r < 3; r++) begin
                d3_neg_reg[r] <= (d2_sum_reg[r] < 0);
            end
            d3_s_reg   <= d2_s_reg;
            d3_u_reg   <= d2_u_reg;
            d3_f_reg   <= d2_f_reg;

            pre_data_reg <= pre_data_next;
        end
    end

    // output register: loads whenever the slot is free or being taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            m_valid_reg <= pre_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !m_valid_reg) begin
            m_data_reg <= pre_data_reg;
        end
    end

    // an empty output slot never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input blocked while output register empty");

    // a held result with a full stage behind it must stop the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && pre_vld_reg) |-> !s_ready)
        else $error("pipeline advanced into a held result");

    // forward row is a unit vector component
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data.m20 <= 32'sd65536 && m_data.m20 >= -32'sd65536))
        else $error("forward component out of unit range");

    // side row is a unit vector component
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data.m00 <= 32'sd65536 && m_data.m00 >= -32'sd65536))
        else $error("side component out of unit range");

endmodule

// ===== rtl/lav_normalize.sv =====
// ============================================================================
// lav_normalize
// pipelined vector normalizer: scale down, square sum, bit-serial root stages,
// restoring divide stages, result in unit Q16.16
// ============================================================================
module lav_normalize (
    input  logic              aclk,
    input  logic              en,
    input  lav_pkg::nrm_vec_t vec_in  [3],
    output lav_pkg::unit_t    vec_out [3]
);

    // magnitude stage
    logic [lav_pkg::MAG_W-1:0]       mag0_reg  [3];
    logic [lav_pkg::MAG_W-1:0]       mag0_next [3];
    logic                            neg0_reg  [3];
    logic                            neg0_next [3];
    logic [lav_pkg::MAG_W-1:0]       or0_reg;
    logic [lav_pkg::MAG_W-1:0]       or0_next;
    // shift count stage
    logic [lav_pkg::MAG_W-1:0]       mag1_reg  [3];
    logic                            neg1_reg  [3];
    logic [lav_pkg::SHIFT_W-1:0]     k1_reg;
    logic [lav_pkg::SHIFT_W-1:0]     k1_next;
    // reduced magnitudes
    logic [lav_pkg::M_W-1:0]         m2_reg    [3];
    logic [lav_pkg::M_W-1:0]         m2_next   [3];
    logic                            neg2_reg  [3];
    // squares
    logic [2*lav_pkg::M_W-1:0]       sq3_reg   [3];
    logic [2*lav_pkg::M_W-1:0]       sq3_next  [3];
    logic [lav_pkg::M_W-1:0]         m3_reg    [3];
    logic                            neg3_reg  [3];
    // root stages, entry 0 holds the squared length
    logic [lav_pkg::SQ_W-1:0]        sv_reg    [lav_pkg::SQRT_STEPS+1];
    logic [lav_pkg::SQ_W-1:0]        sv_next   [lav_pkg::SQRT_STEPS+1];
    logic [lav_pkg::SQ_W-1:0]        sr_reg    [lav_pkg::SQRT_STEPS+1];
    logic [lav_pkg::SQ_W-1:0]        sr_next   [lav_pkg::SQRT_STEPS+1];
    logic [lav_pkg::M_W-1:0]         sm_reg    [lav_pkg::SQRT_STEPS+1][3];
    logic                            sneg_reg  [lav_pkg::SQRT_STEPS+1][3];
    logic                            szero_reg [lav_pkg::SQRT_STEPS+1];
    // divide stages, entry 0 holds the rounded dividend
    logic [lav_pkg::DVD_W-1:0]       drem_reg  [lav_pkg::QUO_W+1][3];
    logic [lav_pkg::DVD_W-1:0]       drem_next [lav_pkg::QUO_W+1][3];
    logic [lav_pkg::QUO_W-1:0]       dq_reg    [lav_pkg::QUO_W+1][3];
    logic [lav_pkg::QUO_W-1:0]       dq_next   [lav_pkg::QUO_W+1][3];
    logic [lav_pkg::ROOT_W-1:0]      dlen_reg  [lav_pkg::QUO_W+1];
    logic                            dneg_reg  [lav_pkg::QUO_W+1][3];
    logic                            dzero_reg [lav_pkg::QUO_W+1];
    // result
    lav_pkg::unit_t                  out_reg   [3];
    lav_pkg::unit_t                  out_next  [3];

    logic [lav_pkg::ROOT_W-1:0]      len;
    logic [lav_pkg::SQ_W-1:0]        trial     [lav_pkg::SQRT_STEPS];
    logic [lav_pkg::SQ_W-1:0]        root_bit  [lav_pkg::SQRT_STEPS];
    logic [lav_pkg::DVD_W:0]         dsub      [lav_pkg::QUO_W];

    assign len = sr_reg[lav_pkg::SQRT_STEPS][lav_pkg::ROOT_W-1:0];

    always_comb begin
        or0_next = '0;
        for (int i = 0; i < 3; i++) begin
            neg0_next[i] = vec_in[i][lav_pkg::NRM_IN_W-1];
            mag0_next[i] = neg0_next[i] ? lav_pkg::MAG_W'(-vec_in[i])
                                        : lav_pkg::MAG_W'(vec_in[i]);
            or0_next     = or0_next | mag0_next[i];
        end
    end

    // halve all together until every magnitude fits below 2^31
    always_comb begin
        k1_next = '0;
        for (int j = lav_pkg::M_W; j < lav_pkg::MAG_W; j++) begin
            if (or0_reg[j]) begin
                k1_next = lav_pkg::SHIFT_W'(j - lav_pkg::M_W + 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m2_next[i]  = lav_pkg::M_W'(mag1_reg[i] >> k1_reg);
            sq3_next[i] = (2*lav_pkg::M_W)'(m2_reg[i]) * (2*lav_pkg::M_W)'(m2_reg[i]);
        end
    end

    // root: one result bit per stage
    always_comb begin
        sv_next[0] = lav_pkg::SQ_W'(sq3_reg[0]) + lav_pkg::SQ_W'(sq3_reg[1])
                   + lav_pkg::SQ_W'(sq3_reg[2]);
        sr_next[0] = '0;
        for (int j = 0; j < lav_pkg::SQRT_STEPS; j++) begin
            root_bit[j] = lav_pkg::SQ_W'(1) << (2 * (lav_pkg::SQRT_STEPS - 1 - j));
            trial[j]    = sr_reg[j] + root_bit[j];
            if (sv_reg[j] >= trial[j]) begin
                sv_next[j+1] = sv_reg[j] - trial[j];
                sr_next[j+1] = (sr_reg[j] >> 1) + root_bit[j];
            end else begin
                sv_next[j+1] = sv_reg[j];
                sr_next[j+1] = sr_reg[j] >> 1;
            end
        end
    end

    // divide: one quotient bit per stage, msb first
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            drem_next[0][i] = (lav_pkg::DVD_W'(sm_reg[lav_pkg::SQRT_STEPS][i])
                               << lav_pkg::FRAC_W) + lav_pkg::DVD_W'(len >> 1);
            dq_next[0][i]   = '0;
        end
        for (int j = 0; j < lav_pkg::QUO_W; j++) begin
            dsub[j] = (lav_pkg::DVD_W + 1)'(dlen_reg[j]) << (lav_pkg::QUO_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, drem_reg[j][i]} >= dsub[j]) begin
                    drem_next[j+1][i] = lav_pkg::DVD_W'({1'b0, drem_reg[j][i]} - dsub[j]);
                    dq_next[j+1][i]   = dq_reg[j][i]
                                      | (lav_pkg::QUO_W'(1) << (lav_pkg::QUO_W - 1 - j));
                end else begin
                    drem_next[j+1][i] = drem_reg[j][i];
                    dq_next[j+1][i]   = dq_reg[j][i];
                end
            end
        end
    end

    // zero length falls back to the unit x vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dzero_reg[lav_pkg::QUO_W]) begin
                out_next[i] = (i == 0) ? lav_pkg::UNIT_ONE : '0;
            end else if (dneg_reg[lav_pkg::QUO_W][i]) begin
                out_next[i] = -lav_pkg::unit_t'({1'b0, dq_reg[lav_pkg::QUO_W][i]});
            end else begin
                out_next[i] = lav_pkg::unit_t'({1'b0, dq_reg[lav_pkg::QUO_W][i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg  <= mag0_next;
            neg0_reg  <= neg0_next;
            or0_reg   <= or0_next;
            mag1_reg  <= mag0_reg;
            neg1_reg  <= neg0_reg;
            k1_reg    <= k1_next;
            m2_reg    <= m2_next;
            neg2_reg  <= neg1_reg;
            sq3_reg   <= sq3_next;
            m3_reg    <= m2_reg;
            neg3_reg  <= neg2_reg;

            sv_reg[0]    <= sv_next[0];
            sr_reg[0]    <= sr_next[0];
            sm_reg[0]    <= m3_reg;
            sneg_reg[0]  <= neg3_reg;
            szero_reg[0] <= (sv_next[0] == '0);
            for (int j = 1; j <= lav_pkg::SQRT_STEPS; j++) begin
                sv_reg[j]    <= sv_next[j];
                sr_reg[j]    <= sr_next[j];
                sm_reg[j]    <= sm_reg[j-1];
                sneg_reg[j]  <= sneg_reg[j-1];
                szero_reg[j] <= szero_reg[j-1];
            end

            drem_reg[0]  <= drem_next[0];
            dq_reg[0]    <= dq_next[0];
            dlen_reg[0]  <= len;
            dneg_reg[0]  <= sneg_reg[lav_pkg::SQRT_STEPS];
            dzero_reg[0] <= szero_reg[lav_pkg::SQRT_STEPS];
            for (int j = 1; j <= lav_pkg::QUO_W; j++) begin
                drem_reg[j]  <= drem_next[j];
                dq_reg[j]    <= dq_next[j];
                dlen_reg[j]  <= dlen_reg[j-1];
                dneg_reg[j]  <= dneg_reg[j-1];
                dzero_reg[j] <= dzero_reg[j-1];
            end

            out_reg <= out_next;
        end
    end

    assign vec_out = out_reg;

endmodule

// ===== verif/look_at_view_matrix_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// look_at_view_matrix_test
// self-checking bench: drives eye/target/up triples through the valid/ready
// input channel, predicts the three view-matrix rows in fixed point and
// compares every result transfer field by field, under random idling
// ============================================================================
module look_at_view_matrix_test;

    localparam int N_RANDOM = 1200;
    localparam int N_CALM   = 200;   // final stretch with no idling
    localparam int DRAIN    = 160;   // a bit more than the pipeline latency
    localparam longint Q_ONE = 65536;

    // ------------------------------------------------------------------------
    // view matrix predictor and store of expected matrices
    // ------------------------------------------------------------------------
    class view_scoreboard;
        lav_pkg::out_t pending[$];
        int   errors;

        function longint unsigned magnitude(longint x);
            return (x < 0) ? longint'(0) - x : x;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Q32.32 to Q16.16, halves away from zero
        function longint to_q16(longint x);
            longint unsigned m;
            m = (magnitude(x) + 64'd32768) >> 16;
            return (x < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // scale an exact vector to unit length; zero vector gives unit x
        function void unitize(input longint v[3], output longint o[3]);
            longint unsigned m[3], sq, len, q;
            for (int i = 0; i < 3; i++) m[i] = magnitude(v[i]);
            while (m[0] >= 64'd2147483648 || m[1] >= 64'd2147483648 ||
                   m[2] >= 64'd2147483648) begin
                for (int i = 0; i < 3; i++) m[i] >>= 1;
            end
            sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            if (sq == 0) begin
                o[0] = Q_ONE;
                o[1] = 0;
                o[2] = 0;
                return;
            end
            len = int_sqrt(sq);
            for (int i = 0; i < 3; i++) begin
                q = (m[i] * 64'd65536 + (len >> 1)) / len;
                o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function longint dot_eye(longint a[3], longint e[3]);
            return to_q16(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
        endfunction

        function void note_input(lav_pkg::in_t x);
            longint eye[3], tgt[3], up[3], d[3], f[3], c[3], s[3], u[3];
            lav_pkg::out_t r;
            eye = '{$signed(x.eye_x), $signed(x.eye_y), $signed(x.eye_z)};
            tgt = '{$signed(x.target_x), $signed(x.target_y), $signed(x.target_z)};
            up  = '{$signed(x.up_x), $signed(x.up_y), $signed(x.up_z)};
            for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
            unitize(d, f);
            c[0] = f[1] * up[2] - f[2] * up[1];
            c[1] = f[2] * up[0] - f[0] * up[2];
            c[2] = f[0] * up[1] - f[1] * up[0];
            unitize(c, s);
            u[0] = to_q16(s[1] * f[2] - s[2] * f[1]);
            u[1] = to_q16(s[2] * f[0] - s[0] * f[2]);
            u[2] = to_q16(s[0] * f[1] - s[1] * f[0]);
            r.m00 = 32'(s[0]);
            r.m01 = 32'(s[1]);
            r.m02 = 32'(s[2]);
            r.m03 = 32'(clamp32(-dot_eye(s, eye)));
            r.m10 = 32'(u[0]);
            r.m11 = 32'(u[1]);
            r.m12 = 32'(u[2]);
            r.m13 = 32'(clamp32(-dot_eye(u, eye)));
            r.m20 = 32'(-f[0]);
            r.m21 = 32'(-f[1]);
            r.m22 = 32'(-f[2]);
            r.m23 = 32'(clamp32(dot_eye(f, eye)));
            pending.push_back(r);
        endfunction

        function void field(string n, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                errors++;
                $error("%s: expected %0d, got %0d", n, $signed(e), $signed(a));
            end
        endfunction

        function void check_result(lav_pkg::out_t a);
            lav_pkg::out_t e;
            if (pending.size() == 0) begin
                errors++;
                $error("result transfer with no matrix expected");
                return;
            end
            e = pending.pop_front();
            field("m00", e.m00, a.m00);
            field("m01", e.m01, a.m01);
            field("m02", e.m02, a.m02);
            field("m03", e.m03, a.m03);
            field("m10", e.m10, a.m10);
            field("m11", e.m11, a.m11);
            field("m12", e.m12, a.m12);
            field("m13", e.m13, a.m13);
            field("m20", e.m20, a.m20);
            field("m21", e.m21, a.m21);
            field("m22", e.m22, a.m22);
            field("m23", e.m23, a.m23);
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    lav_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    lav_pkg::out_t  m_data;
    bit             calm;     // set for the last stretch: no idling on either side

    view_scoreboard sb = new();

    look_at_view_matrix dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watch both channels at the edge, values before any update of this edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // result side: ready drops in short random bursts until the calm stretch
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // one input transfer; valid stays up into the next item unless we idle
    task automatic send(lav_pkg::in_t x);
        s_data  <= x;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // coordinate picker: full range, moderate Q16.16 values, or the extremes
    function automatic logic [31:0] coord();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            4:       return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic lav_pkg::in_t build(logic [31:0] e0, e1, e2, t0, t1, t2,
                                           u0, u1, u2);
        lav_pkg::in_t x;
        x.eye_x    = e0;
        x.eye_y    = e1;
        x.eye_z    = e2;
        x.target_x = t0;
        x.target_y = t1;
        x.target_z = t2;
        x.up_x     = u0;
        x.up_y     = u1;
        x.up_z     = u2;
        return x;
    endfunction

    initial begin
        lav_pkg::in_t x;
        logic [31:0] mx, mn, one, k;
        mx  = 32'h7fffffff;
        mn  = 32'h80000000;
        one = 32'h00010000;
        calm    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ordinary camera, degenerate vectors and range extremes
        send(build(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
        send(build(3 * one, 2 * one, one, -one, 0, 4 * one, 0, 0, one));
        // eye equal to target: forward falls back to unit x
        send(build(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0));
        // zero up vector
        send(build(0, 0, 0, one, one, 0, 0, 0, 0));
        // up parallel to forward
        send(build(0, 0, 0, 0, 0, -one, 0, 0, 7 * one));
        send(build(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // widest differences and saturating translations
        send(build(mn, mn, mn, mx, mx, mx, mx, mn, mx));
        send(build(mx, mx, mx, mn, mn, mn, mn, mx, mn));
        send(build(mx, mn, mx, mn, mx, mn, one, one, one));
        send(build(mn, mx, 0, mx, mn, 0, 0, 0, mn));
        send(build(mx, mx, mx, 0, 0, 0, 0, mx, 0));
        send(build(mn, mn, mn, 0, 0, 0, mn, 0, 0));
        send(build(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send(build(32'hffffffff, 1, 0, 0, 0, 1, 1, 32'hffffffff, 1));
        send(build(mx, 0, 0, mn, 0, 0, 0, one, 0));
        send(build(0, mx, 0, 0, 0, 0, 0, 0, one));

        // random part: mostly general triples, some forced degeneracies
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_CALM) calm = 1'b1;
            x = build(coord(), coord(), coord(), coord(), coord(), coord(),
                      coord(), coord(), coord());
            case ($urandom_range(0, 15))
                0: begin
                    x.target_x = x.eye_x;
                    x.target_y = x.eye_y;
                    x.target_z = x.eye_z;
                end
                1: {x.up_x, x.up_y, x.up_z} = '0;
                2: begin
                    // up along target - eye, scaled by a small integer
                    k = $urandom_range(1, 3);
                    x.eye_x = 32'($signed($urandom_range(0, 200000)) - 100000);
                    x.eye_y = 32'($signed($urandom_range(0, 200000)) - 100000);
                    x.eye_z = 32'($signed($urandom_range(0, 200000)) - 100000);
                    x.up_x  = 32'($signed($urandom_range(0, 200000)) - 100000);
                    x.up_y  = 32'($signed($urandom_range(0, 200000)) - 100000);
                    x.up_z  = 32'($signed($urandom_range(0, 200000)) - 100000);
                    x.target_x = x.eye_x + x.up_x * k;
                    x.target_y = x.eye_y + x.up_y * k;
                    x.target_z = x.eye_z + x.up_z * k;
                end
                default: ;
            endcase
            send(x);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule
